>>> hw/rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   // Request action codes
   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Per-cell control broadcast from the top level
   typedef struct packed {
      logic ins;   // insert accepted this cycle
      logic rem;   // remove accepted this cycle
      logic occ;   // cell currently holds a live entry
      logic tail;  // cell is the first free slot
   } cell_ctl_type;

endpackage

>>> hw/rtl/spq_cell.sv
// One slot of the sorted cell chain: holds a (key, node) entry and shifts with neighbors.
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
#(
   parameter int KEY_BITS  = 32,
   parameter int NODE_BITS = 16
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic                 left_gt,
   input  logic [KEY_BITS-1:0]  left_key,
   input  logic [NODE_BITS-1:0] left_node,
   input  logic [KEY_BITS-1:0]  right_key,
   input  logic [NODE_BITS-1:0] right_node,
   input  logic [KEY_BITS-1:0]  new_key,
   input  logic [NODE_BITS-1:0] new_node,
   output logic                 gt,
   output logic [KEY_BITS-1:0]  key,
   output logic [NODE_BITS-1:0] node
);

   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [NODE_BITS-1:0] node_ff, node_in;

   // live entry strictly greater than the incoming key: it moves back one slot
   assign gt = ctl.occ && (key_ff > new_key);

   always_comb begin
      key_in  = key_ff;
      node_in = node_ff;
      if (ctl.ins) begin
         if (left_gt) begin
            key_in  = left_key;
            node_in = left_node;
         end else if (gt || ctl.tail) begin
            key_in  = new_key;
            node_in = new_node;
         end
      end else if (ctl.rem) begin
         key_in  = right_key;
         node_in = right_node;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      node_ff <= node_in;
   end

   assign key  = key_ff;
   assign node = node_ff;

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, occupancy count and response register.
`timescale 1ns / 1ps
//
// Min-priority queue of (key, node) entries held in a chain of DEPTH cells,
// kept sorted by key ascending; equal keys leave in arrival order.
// Request channel: a transfer happens on a rising edge with start high and
// busy low. busy is always low, so a request can be taken every cycle.
// req_action selects insert (req_item_node, req_item_key) or remove of the
// smallest-key entry.
// Response channel: exactly one response per request, shown for one cycle
// with rsp_strobe high, in the cycle right after the request transfer
// (throughput 1 request per cycle). Every cell decides its next entry in
// parallel from its own compare and its left neighbor's, so each insert
// or remove is applied to the whole chain at once.
// The response carries status (ok, overflow on insert when full, underflow
// on remove when empty; neither error changes the contents), the removed
// node, the head entry after the step, an empty flag and the occupancy.
// The receiver cannot stall: each response is taken in the cycle it shows.
// Reset clears the occupancy count and the strobe; cell contents are
// don't-care until written, and only occupied cells are ever reported.
//
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH     = 128,
   parameter int KEY_BITS  = 32,
   parameter int NODE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [NODE_BITS-1:0]         req_item_node,
   input  logic [KEY_BITS-1:0]          req_item_key,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [NODE_BITS-1:0]         rsp_removed_node,
   output logic [NODE_BITS-1:0]         rsp_head_node,
   output logic [KEY_BITS-1:0]          rsp_head_key,
   output logic                         rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 strobe_ff, strobe_in;
   status_type           status_ff, status_in;
   logic [NODE_BITS-1:0] removed_ff, removed_in;

   logic                 accept, is_full, is_empty, do_ins, do_rem;

   logic [DEPTH-1:0]     gt;
   logic [KEY_BITS-1:0]  cell_key  [DEPTH];
   logic [NODE_BITS-1:0] cell_node [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_ins   = accept && (req_action == ACT_INSERT) && !is_full;
   assign do_rem   = accept && (req_action == ACT_REMOVE) && !is_empty;

   // cell chain: each cell sees its left neighbor's compare and both neighbors' entries
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type         ctl;
      logic                 l_gt;
      logic [KEY_BITS-1:0]  l_key, r_key;
      logic [NODE_BITS-1:0] l_node, r_node;

      assign ctl.ins  = do_ins;
      assign ctl.rem  = do_rem;
      assign ctl.occ  = (CNT_W'(i) < count_ff);
      assign ctl.tail = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_first
         assign l_gt   = 1'b0;
         assign l_key  = '0;
         assign l_node = '0;
      end else begin : g_mid
         assign l_gt   = gt[i-1];
         assign l_key  = cell_key[i-1];
         assign l_node = cell_node[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_key  = cell_key[i];    // vacated slot, content unused
         assign r_node = cell_node[i];
      end else begin : g_inner
         assign r_key  = cell_key[i+1];
         assign r_node = cell_node[i+1];
      end

      spq_cell #(
         .KEY_BITS  (KEY_BITS),
         .NODE_BITS (NODE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_gt    (l_gt),
         .left_key   (l_key),
         .left_node  (l_node),
         .right_key  (r_key),
         .right_node (r_node),
         .new_key    (req_item_key),
         .new_node   (req_item_node),
         .gt         (gt[i]),
         .key        (cell_key[i]),
         .node       (cell_node[i])
      );
   end

   // count and response next values
   always_comb begin
      count_in   = count_ff;
      strobe_in  = accept;
      status_in  = ST_OK;
      removed_in = '0;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in   = count_ff - CNT_W'(1);
         removed_in = cell_node[0];
      end
      if (accept && (req_action == ACT_INSERT) && is_full) begin
         status_in = ST_OVERFLOW;
      end else if (accept && (req_action == ACT_REMOVE) && is_empty) begin
         status_in = ST_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   // head fields read straight from cell 0, which already holds the post-step entry
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_removed_node = removed_ff;
   assign rsp_head_node    = is_empty ? '0 : cell_node[0];
   assign rsp_head_key     = is_empty ? '0 : cell_key[0];
   assign rsp_is_empty     = is_empty;
   assign rsp_occupancy    = count_ff;

endmodule
